// ----- sv/kde_pkg.sv -----
package kde_pkg;

	// Fixed field widths
	localparam int VALUE_W   = 32;
	localparam int DIGIT_W   = 4;
	localparam int CFG_W     = 64;
	localparam int LEN_REG_W = 4;

	// Character and arithmetic constants
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

	// Configuration register indexes
	localparam logic REG_KEYWORD_BYTES  = 1'b0;
	localparam logic REG_KEYWORD_LENGTH = 1'b1;

	// Control from the top level into the accumulator
	typedef struct packed {
		logic               step;
		logic               clear;
		logic [DIGIT_W-1:0] digit;
	} acc_ctrl_t;

	// Accumulator value and saturation flag
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               sat;
	} acc_stat_t;

endpackage

// ----- sv/kde_cell.sv -----
module kde_cell import kde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic [7:0] byte_in,
	input  logic [7:0] key_char,
	input  logic       use_en,
	output logic [7:0] byte_out,
	output logic       hit
);

	logic [7:0] byte_q;

	// Compare the byte that moves in against this position's keyword char
	assign hit = !use_en || (byte_in == key_char);
	assign byte_out = byte_q;

	// Window position; takes the neighbor's byte on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= byte_in;
		end
	end

endmodule

// ----- sv/kde_accum.sv -----
module kde_accum import kde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  acc_ctrl_t ctrl,
	output acc_stat_t stat_q,
	output acc_stat_t stat_next
);

	localparam int WIDE_W = VALUE_W + DIGIT_W;

	logic [WIDE_W-1:0] prod;
	logic [WIDE_W-1:0] sum;
	acc_stat_t         reg_q;

	// value * 10 + digit, saturating at all ones
	always_comb begin
		prod = WIDE_W'(reg_q.value) * WIDE_W'(DEC_BASE);
		sum  = prod + WIDE_W'(ctrl.digit);
		stat_next = reg_q;
		if (ctrl.step && !reg_q.sat) begin
			if (sum[WIDE_W-1:VALUE_W] != '0) begin
				stat_next.value = '1;
				stat_next.sat   = 1'b1;
			end else begin
				stat_next.value = sum[VALUE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q <= '0;
		end else if (ctrl.clear) begin
			reg_q <= '0;
		end else begin
			reg_q <= stat_next;
		end
	end

	assign stat_q = reg_q;

endmodule

// ----- sv/keyword_decimal_extractor_unit.sv -----
// Keyword search and decimal parse over a byte stream.
// Input channel (in_valid/in_ready): data_byte, last_byte marks the end of
// a buffer. Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0
// writes keyword_bytes (first char in the low byte), 1 writes
// keyword_length (0 acts as 1, above MAX_KEY_LEN acts as MAX_KEY_LEN).
// Output channel (out_valid/out_ready): found, number_value, overflow.
// One result per buffer: at the first non-digit after the keyword match,
// or at the last byte. The result appears in the cycle after the byte
// that causes it. Throughput is one byte per cycle while in_ready is
// high: the keyword window is a row of byte cells compared in parallel,
// and the value update is one multiply by ten and add per cycle.
// A single output register holds the result; a new byte is taken while
// it is being drained. When the receiver stalls with a result pending,
// in_ready drops until the result is taken.
// Reset clears the window, match and value state, the output register,
// and sets the keyword to zero with length one. The last byte of each
// buffer clears the search state; the configuration is kept.
module keyword_decimal_extractor_unit import kde_pkg::*; #(
	parameter int MAX_KEY_LEN = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [VALUE_W-1:0] number_value,
	output logic               overflow
);

	localparam int KEY_BITS = 8 * MAX_KEY_LEN;
	localparam int LEN_W    = $clog2(MAX_KEY_LEN + 1);
	localparam int IDX_W    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

	logic [KEY_BITS-1:0]  key_q;
	logic [LEN_REG_W-1:0] len_q;
	logic [LEN_W-1:0]     fill_q;
	logic                 matched_q;
	logic                 reported_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 ovf_q;

	logic                 take;
	logic                 is_digit;
	logic                 shift_en;
	logic [LEN_W-1:0]     n_eff;
	logic [LEN_W-1:0]     fill_next;
	logic                 window_hit;
	logic                 matched_n;
	logic                 reported_n;
	logic                 emit;
	acc_ctrl_t            acc_ctrl;
	acc_stat_t            acc_q;
	acc_stat_t            acc_n;

	logic [7:0]           cell_in  [MAX_KEY_LEN];
	logic [7:0]           cell_out [MAX_KEY_LEN];
	logic [7:0]           cell_key [MAX_KEY_LEN];
	logic [MAX_KEY_LEN-1:0] cell_use;
	logic [MAX_KEY_LEN-1:0] cell_hit;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			len_q <= LEN_REG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEYWORD_BYTES:  key_q <= cfg_data[KEY_BITS-1:0];
				REG_KEYWORD_LENGTH: len_q <= cfg_data[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective keyword length, clamped to 1..MAX_KEY_LEN
	always_comb begin
		if (len_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (len_q > LEN_REG_W'(MAX_KEY_LEN)) begin
			n_eff = LEN_W'(MAX_KEY_LEN);
		end else begin
			n_eff = len_q[LEN_W-1:0];
		end
	end

	// Row of window cells; cell 0 holds the newest byte
	genvar gi;
	generate
		for (gi = 0; gi < MAX_KEY_LEN; gi++) begin : g_cell
			logic [LEN_W-1:0] sel;
			assign sel          = n_eff - LEN_W'(gi + 1);
			assign cell_use[gi] = n_eff > LEN_W'(gi);
			assign cell_key[gi] = key_q[8*sel[IDX_W-1:0] +: 8];
			if (gi == 0) begin : g_head
				assign cell_in[gi] = data_byte;
			end else begin : g_link
				assign cell_in[gi] = cell_out[gi-1];
			end
			kde_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.byte_in  (cell_in[gi]),
				.key_char (cell_key[gi]),
				.use_en   (cell_use[gi]),
				.byte_out (cell_out[gi]),
				.hit      (cell_hit[gi])
			);
		end
	endgenerate

	assign fill_next  = (fill_q < LEN_W'(MAX_KEY_LEN)) ? fill_q + LEN_W'(1) : fill_q;
	assign window_hit = (&cell_hit) && (fill_next >= n_eff);

	// Per-item control: search, then digits, then report
	always_comb begin
		shift_en       = 1'b0;
		matched_n      = matched_q;
		reported_n     = reported_q;
		emit           = 1'b0;
		acc_ctrl.step  = 1'b0;
		acc_ctrl.clear = take && last_byte;
		acc_ctrl.digit = data_byte[DIGIT_W-1:0] - CHAR_ZERO[DIGIT_W-1:0];
		if (take && !reported_q) begin
			if (!matched_q) begin
				shift_en  = 1'b1;
				matched_n = window_hit;
			end else if (is_digit) begin
				acc_ctrl.step = 1'b1;
			end else begin
				emit       = 1'b1;
				reported_n = 1'b1;
			end
			if (last_byte) begin
				emit = 1'b1;
			end
		end
	end

	kde_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (acc_ctrl),
		.stat_q    (acc_q),
		.stat_next (acc_n)
	);

	// Search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			matched_q  <= 1'b0;
			reported_q <= 1'b0;
		end else if (take && last_byte) begin
			fill_q     <= '0;
			matched_q  <= 1'b0;
			reported_q <= 1'b0;
		end else if (take) begin
			if (shift_en) begin
				fill_q <= fill_next;
			end
			matched_q  <= matched_n;
			reported_q <= reported_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			value_q <= '0;
			ovf_q   <= 1'b0;
		end else if (emit) begin
			found_q <= matched_n;
			value_q <= matched_n ? acc_n.value : '0;
			ovf_q   <= matched_n && acc_n.sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign number_value = value_q;
	assign overflow     = ovf_q;

`ifndef NO_ASSERTIONS
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> found && (number_value == '1))
		else $error("overflow without found or saturated value");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (number_value == '0) && !overflow)
		else $error("missing keyword with nonzero value");
	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.sat |-> (acc_q.value == '1))
		else $error("saturated accumulator not all ones");
	a_rep_match: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> matched_q)
		else $error("report taken before a match");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import kde_pkg::*;

	localparam int MAX_KEY      = 8;
	localparam int PLAN_ROWS    = 26;
	localparam int RANDOM_ITEMS = 800;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic {
		ROW_BYTE,
		ROW_KEY
	} row_kind_t;

	// One directed step: either a keyword setting or one byte of a buffer
	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_W-1:0]   key;
		logic [CFG_W-1:0]   key_len;
		logic [7:0]         b;
		logic               l;
		logic               pinned;
		logic               pin_found;
		logic [VALUE_W-1:0] pin_value;
		logic               pin_ovf;
	} plan_row_t;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] value;
		logic               ovf;
	} scan_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic [VALUE_W-1:0] number_value;
	logic               overflow;

	// Shadow of the scanner: keyword settings and per-buffer search state
	logic [CFG_W-1:0]   key_bytes_m;
	logic [3:0]         key_len_m;
	logic [7:0]         window_m [MAX_KEY];
	int                 fill_m;
	bit                 hit_m;
	bit                 done_m;
	bit                 sat_m;
	logic [VALUE_W-1:0] acc_m;

	scan_result_t results_due [$];
	plan_row_t    plan [PLAN_ROWS];
	int           mismatches   = 0;
	int           items_live   = 0;
	int           stall_left   = 0;
	int unsigned  cycle_count  = 0;
	bit           calm         = 1'b0;
	string        key_alphabet = "ab=:";

	keyword_decimal_extractor_unit #(
		.MAX_KEY_LEN(MAX_KEY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.number_value(number_value),
		.overflow(overflow)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
				results_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Receiver drops out_ready at random, in bursts, unless calm is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result found=%0b value=%0d ovf=%0b",
					found, number_value, overflow));
			end else begin
				want = results_due.pop_front();
				if (found !== want.found)
					flag_mismatch($sformatf("found got %0b want %0b", found, want.found));
				if (number_value !== want.value)
					flag_mismatch($sformatf("number_value got %0d want %0d",
						number_value, want.value));
				if (overflow !== want.ovf)
					flag_mismatch($sformatf("overflow got %0b want %0b", overflow, want.ovf));
			end
		end
	end

	// Keyword length as the scanner uses it: 0 acts as 1, above the max clamps
	function automatic int key_span();
		if (key_len_m == 4'd0)
			return 1;
		if (key_len_m > MAX_KEY)
			return MAX_KEY;
		return key_len_m;
	endfunction

	function automatic scan_result_t scan_snapshot();
		scan_result_t r;
		r.found = hit_m;
		r.value = hit_m ? acc_m : '0;
		r.ovf   = hit_m && sat_m;
		return r;
	endfunction

	task automatic clear_scan();
		foreach (window_m[i])
			window_m[i] = '0;
		fill_m = 0;
		hit_m  = 1'b0;
		done_m = 1'b0;
		sat_m  = 1'b0;
		acc_m  = '0;
	endtask

	// Advance the shadow scanner by one byte; emits is set when a result is due
	task automatic scan_byte(input logic [7:0] b, input logic l, output bit emits,
		output scan_result_t r);
		logic [63:0] sum;
		bit          eq;
		int          n;
		emits = 1'b0;
		r = '0;
		if (!done_m) begin
			if (!hit_m) begin
				// shift the window, newest byte at entry 0
				for (int i = MAX_KEY - 1; i > 0; i--)
					window_m[i] = window_m[i - 1];
				window_m[0] = b;
				if (fill_m < MAX_KEY)
					fill_m++;
				n = key_span();
				eq = (fill_m >= n);
				for (int i = 0; i < n; i++)
					if (window_m[n - 1 - i] != key_bytes_m[8 * i +: 8])
						eq = 1'b0;
				if (eq)
					hit_m = 1'b1;
			end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
				// one decimal digit, saturating at the top of 32 bits
				if (!sat_m) begin
					sum = {32'd0, acc_m} * {60'd0, DEC_BASE} + {56'd0, b - CHAR_ZERO};
					if (sum > {32'd0, {VALUE_W{1'b1}}}) begin
						acc_m = '1;
						sat_m = 1'b1;
					end else begin
						acc_m = sum[VALUE_W-1:0];
					end
				end
			end else begin
				emits  = 1'b1;
				r      = scan_snapshot();
				done_m = 1'b1;
			end
			if (l && !done_m) begin
				emits = 1'b1;
				r     = scan_snapshot();
			end
		end
		if (l)
			clear_scan();
	endtask

	// Present one item and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic l, input bit pinned,
		input scan_result_t pin_res);
		bit           emits;
		scan_result_t r;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (!in_ready);
		items_live++;
		scan_byte(b, l, emits, r);
		if (emits || pinned)
			results_due.push_back(pinned ? pin_res : r);
	endtask

	// Drop the input and let every outstanding result drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_keyword(input logic [CFG_W-1:0] key, input logic [CFG_W-1:0] len_word);
		cfg_valid <= 1'b1;
		cfg_index <= REG_KEYWORD_BYTES;
		cfg_data  <= key;
		do
			@(posedge clk);
		while (!cfg_ready);
		key_bytes_m = key;
		cfg_index <= REG_KEYWORD_LENGTH;
		cfg_data  <= len_word;
		do
			@(posedge clk);
		while (!cfg_ready);
		key_len_m = len_word[3:0];
		cfg_valid <= 1'b0;
	endtask

	// Random keyword, often from a small alphabet so partial matches show up in noise
	task automatic new_keyword();
		logic [CFG_W-1:0] kb;
		logic [CFG_W-1:0] lw;
		int               len;
		kb = {$urandom, $urandom};
		if ($urandom_range(0, 2) != 0)
			for (int i = 0; i < MAX_KEY; i++)
				kb[8 * i +: 8] = key_alphabet[$urandom_range(0, 3)];
		len = $urandom_range(1, MAX_KEY);
		if ($urandom_range(0, 4) == 0)
			len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_KEY + 1, 15);
		lw = {$urandom, $urandom};
		lw[3:0] = len[3:0];
		set_keyword(kb, lw);
	endtask

	function automatic logic [7:0] noise_byte();
		int k;
		k = $urandom_range(0, MAX_KEY - 1);
		case ($urandom_range(0, 3))
			0, 1: return key_bytes_m[8 * k +: 8];
			2: return CHAR_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One buffer: mostly prefix, keyword, digits, terminator; some pure noise
	task automatic random_buffer();
		logic [7:0] bytes_q [$];
		logic [7:0] b;
		int         n;
		int         ndig;
		string      digits;
		scan_result_t none;
		none = '0;
		n = key_span();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12))
				bytes_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 6))
				bytes_q.push_back(noise_byte());
			// broken keyword now and then: its last character is dropped
			for (int i = 0; i < n; i++)
				if (!(i == n - 1 && $urandom_range(0, 7) == 0))
					bytes_q.push_back(key_bytes_m[8 * i +: 8]);
			case ($urandom_range(0, 9))
				0, 1: ndig = 0;
				7: ndig = $urandom_range(9, 11);
				9: ndig = $urandom_range(12, 14);
				default: ndig = $urandom_range(1, 5);
			endcase
			if ($urandom_range(0, 9) == 0) begin
				// right at and just past the top of the 32-bit range
				digits = $urandom_range(0, 1) ? "4294967295" : "4294967296";
				foreach (digits[i])
					bytes_q.push_back(digits[i]);
			end else begin
				repeat (ndig)
					bytes_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 1) == 0) begin
				do
					b = 8'($urandom_range(0, 255));
				while (b >= CHAR_ZERO && b <= CHAR_NINE);
				bytes_q.push_back(b);
				repeat ($urandom_range(0, 3))
					bytes_q.push_back(noise_byte());
			end
		end
		if (bytes_q.size() == 0)
			bytes_q.push_back(noise_byte());
		foreach (bytes_q[i])
			send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, none);
	endtask

	initial begin
		scan_result_t pin;
		plan = '{
			// reset keyword is a single zero byte
			'{ROW_BYTE, '0, '0, "A", 1'b1, 1'b1, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b1, 1'b1, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "x", 1'b1, 1'b0, 1'b0, '0, 1'b0},
			// "=" with length register 0, digits run past 32 bits to the last byte
			'{ROW_KEY, 64'h3D, '0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "=", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "4", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "2", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "9", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "4", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "9", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "6", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "7", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "2", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "9", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "6", 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, "7", 1'b1, 1'b1, 1'b1, '1, 1'b1},
			// all-ones keyword, length register 15 clamps to 8, match on the last byte
			'{ROW_KEY, '1, '1, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, '0, 1'b0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b1, '0, 1'b0}
		};

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_KEYWORD_BYTES;
		cfg_data  <= '0;
		out_ready <= 1'b0;
		key_bytes_m = '0;
		key_len_m   = 4'd1;
		clear_scan();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_KEY) begin
				wait_idle();
				set_keyword(plan[i].key, plan[i].key_len);
			end else begin
				pin.found = plan[i].pin_found;
				pin.value = plan[i].pin_value;
				pin.ovf   = plan[i].pin_ovf;
				send_byte(plan[i].b, plan[i].l, plan[i].pinned, pin);
			end
		end

		// random buffers, keyword changed now and then; no idling near the end
		while (items_live < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				new_keyword();
			end
			calm = (items_live > RANDOM_ITEMS * 85 / 100);
			random_buffer();
		end

		wait_idle();
		if (results_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/kde_pkg.sv
sv/kde_cell.sv
sv/kde_accum.sv
sv/keyword_decimal_extractor_unit.sv
verif/testbench.sv
